/* rtl/mqrf_pkg.sv */
// Shared types and constants for the multi-queue command ring bank.
// Used by every module of the block; depends on nothing else.
package mqrf_pkg;

    localparam int MODE_W   = 2;
    localparam int SEL_W    = 4;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

    // One stored command, 256 bits.
    typedef struct packed {
        logic [31:0] cmd;
        logic [31:0] flags;
        logic [63:0] arg_a;
        logic [63:0] arg_b;
        logic [63:0] arg_c;
    } t_entry;

    // Port strobes from the controller to the entry memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* rtl/mqrf_store.sv */
// Entry memory: one write port and one read port with registered read data.
// Depends on mqrf_pkg for the entry and strobe types.
module mqrf_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                  i_clk,
    input  mqrf_pkg::t_mem_ctl    i_ctl,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  mqrf_pkg::t_entry      i_wr_data,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output mqrf_pkg::t_entry      o_rd_data
);

    mqrf_pkg::t_entry r_mem [DEPTH];
    mqrf_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mqrf_ctrl.sv */
// Per-queue write and read counters, command decode and the result register.
// Depends on mqrf_pkg; drives the entry memory in mqrf_store.
module mqrf_ctrl #(
    parameter int QUEUE_COUNT = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int QW          = 3,
    parameter int IW          = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mqrf_pkg::MODE_W-1:0]      i_mode,
    input  logic [mqrf_pkg::SEL_W-1:0]       i_queue_sel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mqrf_pkg::STATUS_W-1:0]    o_status,
    output logic [mqrf_pkg::PEND_W-1:0]      o_pending_count,
    output mqrf_pkg::t_entry                 o_out_data,
    output mqrf_pkg::t_mem_ctl               o_mem_ctl,
    output logic [QW+IW-1:0]                 o_wr_addr,
    output logic [QW+IW-1:0]                 o_rd_addr,
    input  mqrf_pkg::t_entry                 i_rd_data
);

    localparam int CW = IW + 1;

    logic [CW-1:0] r_wcnt [QUEUE_COUNT];
    logic [CW-1:0] r_rcnt [QUEUE_COUNT];

    mqrf_pkg::t_state  r_state, n_state;
    mqrf_pkg::t_status r_status, n_status;
    logic [mqrf_pkg::PEND_W-1:0] r_pend, n_pend;
    logic              r_pop_ok, n_pop_ok;

    logic                           r_out_valid, n_out_valid;
    mqrf_pkg::t_status              r_out_status;
    logic [mqrf_pkg::PEND_W-1:0]    r_out_pend;
    mqrf_pkg::t_entry               r_out_data;

    logic [QW-1:0]  q_idx;
    logic           bad_q;
    logic [CW-1:0]  wcnt, rcnt, occ;
    logic           accept, do_push, do_pop, load;
    logic [mqrf_pkg::PEND_W+CW-1:0] occ_ext;

    assign q_idx   = i_queue_sel[QW-1:0];
    assign bad_q   = {1'b0, i_queue_sel} >= (mqrf_pkg::SEL_W+1)'(QUEUE_COUNT);
    assign wcnt    = r_wcnt[q_idx];
    assign rcnt    = r_rcnt[q_idx];
    assign occ     = wcnt - rcnt;
    assign occ_ext = {{mqrf_pkg::PEND_W{1'b0}}, occ};
    assign accept  = i_in_valid && (r_state == mqrf_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_pend      = r_pend;
        n_pop_ok    = r_pop_ok;
        n_out_valid = r_out_valid;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        load        = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            mqrf_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = mqrf_pkg::ST_OK;
                    n_pend   = '0;
                    n_pop_ok = 1'b0;
                    n_state  = mqrf_pkg::S_LOAD;
                    if (bad_q) begin
                        n_status = mqrf_pkg::ST_BAD;
                    end else begin
                        unique case (mqrf_pkg::t_mode'(i_mode))
                            mqrf_pkg::MODE_PUSH: begin
                                if (occ >= CW'(QUEUE_DEPTH)) begin
                                    n_status = mqrf_pkg::ST_FULL;
                                end else begin
                                    do_push = 1'b1;
                                end
                            end
                            mqrf_pkg::MODE_POP: begin
                                if (wcnt == rcnt) begin
                                    n_status = mqrf_pkg::ST_EMPTY;
                                end else begin
                                    do_pop   = 1'b1;
                                    n_pop_ok = 1'b1;
                                end
                            end
                            mqrf_pkg::MODE_QUERY: begin
                                n_pend = occ_ext[mqrf_pkg::PEND_W-1:0];
                            end
                            default: begin
                                n_status = mqrf_pkg::ST_OK;
                            end
                        endcase
                    end
                end
            end
            mqrf_pkg::S_LOAD: begin
                if (!r_out_valid || !i_out_stall) begin
                    load        = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = mqrf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mqrf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqrf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < QUEUE_COUNT; k++) begin
                r_wcnt[k] <= '0;
                r_rcnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (do_push) begin
                r_wcnt[q_idx] <= wcnt + CW'(1);
            end
            if (do_pop) begin
                r_rcnt[q_idx] <= rcnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pend   <= n_pend;
        r_pop_ok <= n_pop_ok;
        if (load) begin
            r_out_status <= r_status;
            r_out_pend   <= r_pend;
            r_out_data   <= r_pop_ok ? i_rd_data : '0;
        end
    end

    assign o_mem_ctl.wr_en  = do_push;
    assign o_mem_ctl.rd_en  = do_pop;
    assign o_wr_addr        = {q_idx, wcnt[IW-1:0]};
    assign o_rd_addr        = {q_idx, rcnt[IW-1:0]};
    assign o_in_stall       = (r_state != mqrf_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_pending_count  = r_out_pend;
    assign o_out_data       = r_out_data;

endmodule

/* rtl/multi_queue_ring_fifo_top.sv */
// A result lands in the output register from the load state that follows acceptance,
// once the output register is free; the input stalls until then. The load state waits
// on the registered read port of the entry memory before the result register loads.
// Reset (synchronous, active low) clears all queue counters and the state; the entry
// memory is not cleared, and the block takes items as soon as reset is released.
// Top level of the multi-queue command ring bank; uses mqrf_pkg, mqrf_ctrl, mqrf_store.
module multi_queue_ring_fifo_top #(
    parameter int QUEUE_COUNT = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mqrf_pkg::MODE_W-1:0]      i_mode,
    input  logic [mqrf_pkg::SEL_W-1:0]       i_queue_sel,
    input  logic [31:0]                      i_cmd_in,
    input  logic [31:0]                      i_flags_in,
    input  logic [63:0]                      i_arg_a_in,
    input  logic [63:0]                      i_arg_b_in,
    input  logic [63:0]                      i_arg_c_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mqrf_pkg::STATUS_W-1:0]    o_status,
    output logic [31:0]                      o_cmd_out,
    output logic [31:0]                      o_flags_out,
    output logic [63:0]                      o_arg_a_out,
    output logic [63:0]                      o_arg_b_out,
    output logic [63:0]                      o_arg_c_out,
    output logic [mqrf_pkg::PEND_W-1:0]      o_pending_count
);

    // Each queue owns a contiguous slice of the entry memory. Because the queue
    // depth is a power of two, the address is simply the queue number above the
    // ring index. A single queue still gets one address bit for its number.
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int AW = QW + IW;
    localparam int MEM_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;

    mqrf_pkg::t_mem_ctl mem_ctl;
    mqrf_pkg::t_entry   wr_data;
    mqrf_pkg::t_entry   rd_data;
    mqrf_pkg::t_entry   out_data;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    // A push writes the incoming item straight into its slot at acceptance.
    assign wr_data.cmd   = i_cmd_in;
    assign wr_data.flags = i_flags_in;
    assign wr_data.arg_a = i_arg_a_in;
    assign wr_data.arg_b = i_arg_b_in;
    assign wr_data.arg_c = i_arg_c_in;

    // The controller decodes the item, updates the counters at acceptance and
    // issues the memory read for a pop. A pop only reads a slot that an earlier
    // push already wrote, so the ports never collide on an entry.
    mqrf_ctrl #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .IW          (IW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_queue_sel     (i_queue_sel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_pending_count (o_pending_count),
        .o_out_data      (out_data),
        .o_mem_ctl       (mem_ctl),
        .o_wr_addr       (wr_addr),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

    mqrf_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Data fields read zero unless the item was a successful pop.
    assign o_cmd_out   = out_data.cmd;
    assign o_flags_out = out_data.flags;
    assign o_arg_a_out = out_data.arg_a;
    assign o_arg_b_out = out_data.arg_b;
    assign o_arg_c_out = out_data.arg_c;

endmodule

/* rtl/mqrf_checker.sv */
// Port-level checks for the multi-queue command ring bank, bound to its top level.
// Depends on mqrf_pkg for the status codes.
module mqrf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [mqrf_pkg::STATUS_W-1:0]    o_status,
    input logic [31:0]                      o_cmd_out,
    input logic [31:0]                      o_flags_out,
    input logic [63:0]                      o_arg_a_out,
    input logic [63:0]                      o_arg_b_out,
    input logic [63:0]                      o_arg_c_out,
    input logic [mqrf_pkg::PEND_W-1:0]      o_pending_count
);

    logic in_acc;
    logic data_zero;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign data_zero = (o_cmd_out == '0) && (o_flags_out == '0) && (o_arg_a_out == '0)
                       && (o_arg_b_out == '0) && (o_arg_c_out == '0);

    // An accepted item stalls the input in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken on the cycle after an accepted item");

    // Only a result with an ok status may carry command data.
    a_data_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != mqrf_pkg::ST_OK)) |-> data_zero)
        else $error("command data present on a failed or bad-queue result");

    // A nonzero occupancy is only reported with an ok status and no data.
    a_pend_only_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pending_count != '0)) |-> ((o_status == mqrf_pkg::ST_OK)
        && data_zero))
        else $error("occupancy reported on a non-query result");

    // A stalled result stays presented.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_status) && $stable(o_cmd_out)
        && $stable(o_pending_count) && $stable(o_arg_a_out)))
        else $error("result payload changed while stalled");

endmodule

bind multi_queue_ring_fifo_top mqrf_checker u_mqrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_cmd_out       (o_cmd_out),
    .o_flags_out     (o_flags_out),
    .o_arg_a_out     (o_arg_a_out),
    .o_arg_b_out     (o_arg_b_out),
    .o_arg_c_out     (o_arg_c_out),
    .o_pending_count (o_pending_count)
);
